// ----- src/grmt_pkg.sv -----
// Shared types and constants of the guard range match table.
package grmt_pkg;

  localparam int unsigned NUM_SLOTS = 64;
  localparam int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned CHAR_W    = 6;
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned BCD_W     = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W     = $clog2(ID_W);
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    MODE_REG    = 2'd0,
    MODE_DEREG  = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_REGISTERED = 3'd0,
    ST_FULL       = 3'd1,
    ST_REMOVED    = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_HIT        = 3'd4,
    ST_MISS       = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ID_W-1:0]   pool_id;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic [ADDR_W-1:0] fault_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ID_W-1:0]   hit_pool_id;
    logic [CHAR_W-1:0] char_thousands;
    logic [CHAR_W-1:0] char_hundreds;
    logic [CHAR_W-1:0] char_tens;
    logic [CHAR_W-1:0] char_ones;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    scan_inc;
    logic    commit;
    logic    conv_start;
    logic    conv_step;
    logic    out_load;
    logic    hit;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       match;
    logic       last;
    logic       conv_done;
    logic       out_free;
  } dp_stat_t;

endpackage

// ----- src/grmt_ctrl.sv -----
// Controller state machine of the guard range match table.
module grmt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_mode_i,
  output logic                in_ready_o,
  input  grmt_pkg::dp_stat_t  stat_i,
  output grmt_pkg::ctrl_cmd_t cmd_o
);
  import grmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_CONV,
    S_DONE
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    hit_q, hit_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    hit_d    = hit_q;
    cmd_o    = '0;
    cmd_o.status = status_q;
    cmd_o.hit    = hit_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          hit_d      = 1'b0;
          if (in_mode_i == MODE_NONE) begin
            status_d = ST_MISS;
            state_d  = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.match) begin
          cmd_o.commit = 1'b1;
          case (stat_i.mode)
            MODE_REG: begin
              status_d = ST_REGISTERED;
              state_d  = S_DONE;
            end
            MODE_DEREG: begin
              status_d = ST_REMOVED;
              state_d  = S_DONE;
            end
            default: begin
              status_d         = ST_HIT;
              hit_d            = 1'b1;
              cmd_o.conv_start = 1'b1;
              state_d          = S_CONV;
            end
          endcase
        end else if (stat_i.last) begin
          case (stat_i.mode)
            MODE_REG:   status_d = ST_FULL;
            MODE_DEREG: status_d = ST_NOT_FOUND;
            default:    status_d = ST_MISS;
          endcase
          state_d = S_DONE;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_READ;
        end
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (stat_i.conv_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_MISS;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      hit_q    <= hit_d;
    end
  end

endmodule

// ----- src/grmt_datapath.sv -----
// Datapath of the guard range match table: slot memory, scan, digit split, output register.
module grmt_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  grmt_pkg::in_item_t  in_data_i,
  input  grmt_pkg::ctrl_cmd_t cmd_i,
  output grmt_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output grmt_pkg::out_item_t out_data_o
);
  import grmt_pkg::*;

  logic [ADDR_W-1:0] mem_start [NUM_SLOTS];
  logic [ADDR_W-1:0] mem_end   [NUM_SLOTS];
  logic [ID_W-1:0]   mem_pool  [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] valid_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 out_valid_q;
  in_item_t             item_q;
  out_item_t            out_q;
  logic [ADDR_W-1:0]    rd_start_q, rd_end_q;
  logic [ID_W-1:0]      rd_pool_q;
  logic [ID_W-1:0]      bin_q, hit_id_q;
  logic [BCD_W-1:0]     bcd_q, bcd_adj;
  logic [CNT_W-1:0]     cnt_q;
  logic                 slot_valid;
  logic                 match;

  assign slot_valid = valid_q[idx_q];

  always_comb begin
    case (item_q.mode)
      MODE_REG:    match = !slot_valid;
      MODE_DEREG:  match = slot_valid && (rd_pool_q == item_q.pool_id);
      MODE_LOOKUP: match = slot_valid && (rd_start_q <= item_q.fault_addr)
                           && (item_q.fault_addr < rd_end_q);
      default:     match = 1'b0;
    endcase
  end

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
                                                     : bcd_q[4*d +: 4];
    end
  end

  assign stat_o.mode      = item_q.mode;
  assign stat_o.match     = match;
  assign stat_o.last      = (idx_q == IDX_W'(NUM_SLOTS - 1));
  assign stat_o.conv_done = (cnt_q == CNT_W'(ID_W - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.scan_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.commit && item_q.mode == MODE_REG) begin
        valid_q[idx_q] <= 1'b1;
      end else if (cmd_i.commit && item_q.mode == MODE_DEREG) begin
        valid_q[idx_q] <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_start_q <= mem_start[idx_q];
    rd_end_q   <= mem_end[idx_q];
    rd_pool_q  <= mem_pool[idx_q];
    if (cmd_i.commit && item_q.mode == MODE_REG) begin
      mem_start[idx_q] <= item_q.range_start;
      mem_end[idx_q]   <= item_q.range_end;
      mem_pool[idx_q]  <= item_q.pool_id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.conv_start) begin
      bin_q    <= rd_pool_q;
      hit_id_q <= rd_pool_q;
      bcd_q    <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.conv_step) begin
      {bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
      cnt_q          <= cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_q.status <= cmd_i.status;
      if (cmd_i.hit) begin
        out_q.hit_pool_id    <= hit_id_q;
        out_q.char_thousands <= ASCII_ZERO + CHAR_W'(bcd_q[15:12]);
        out_q.char_hundreds  <= ASCII_ZERO + CHAR_W'(bcd_q[11:8]);
        out_q.char_tens      <= ASCII_ZERO + CHAR_W'(bcd_q[7:4]);
        out_q.char_ones      <= ASCII_ZERO + CHAR_W'(bcd_q[3:0]);
      end else begin
        out_q.hit_pool_id    <= '0;
        out_q.char_thousands <= ASCII_ZERO;
        out_q.char_hundreds  <= ASCII_ZERO;
        out_q.char_tens      <= ASCII_ZERO;
        out_q.char_ones      <= ASCII_ZERO;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/guard_range_match_table.sv -----
// Top level of the guard range match table.
//
//   channel | direction | handshake               | payload
//   input   | in        | in_valid_i / in_ready_o   | in_data_i  (grmt_pkg::in_item_t)
//   output  | out       | out_valid_o / out_ready_i | out_data_o (grmt_pkg::out_item_t)
//
// Slots live in a single-port memory read one slot per S_READ/S_CHECK pass, so a register,
// deregister or lookup visits slots in turn, up to NUM_SLOTS of them.
// A lookup hit adds a serial binary to BCD split of the pool id.
// An unknown mode skips the scan and goes straight from accept to result hand-off.
// Reset clears the slot valid flip-flops at once; no clearing pass is needed.
// A waiting result is held in the output register while the next transaction is accepted.
module guard_range_match_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  grmt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output grmt_pkg::out_item_t out_data_o
);
  import grmt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  grmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  grmt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- bench/guard_range_match_table_tb.sv -----
// Self-checking testbench of the guard range match table.
`timescale 1ns / 1ps

module guard_range_match_table_tb;
  import grmt_pkg::*;

  localparam int unsigned TABLE_DEPTH = NUM_SLOTS;
  localparam int unsigned RAND_ITEMS  = 1600;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  guard_range_match_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Shadow copy of the table.
  logic              tbl_valid [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_start [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_end   [TABLE_DEPTH];
  logic [ID_W-1:0]   tbl_pool  [TABLE_DEPTH];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int unsigned error_count = 0;
  bit stimulus_done = 0;
  bit hold_sender = 0;

  // Recently used values, so random lookups and deregisters hit often.
  logic [ID_W-1:0]   used_ids[$];
  logic [ADDR_W-1:0] used_addrs[$];

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic out_item_t table_answer(status_e st, logic [ID_W-1:0] id, bit hit);
    out_item_t r;
    r.status         = st;
    r.hit_pool_id    = hit ? id : '0;
    r.char_thousands = hit ? ASCII_ZERO + CHAR_W'((id / 1000) % 10) : ASCII_ZERO;
    r.char_hundreds  = hit ? ASCII_ZERO + CHAR_W'((id / 100) % 10) : ASCII_ZERO;
    r.char_tens      = hit ? ASCII_ZERO + CHAR_W'((id / 10) % 10) : ASCII_ZERO;
    r.char_ones      = hit ? ASCII_ZERO + CHAR_W'(id % 10) : ASCII_ZERO;
    return r;
  endfunction

  // Applies one transaction to the shadow table and returns its answer.
  function automatic out_item_t apply_table_op(in_item_t it);
    case (mode_e'(it.mode))
      MODE_REG: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_start[i] = it.range_start;
            tbl_end[i]   = it.range_end;
            tbl_pool[i]  = it.pool_id;
            return table_answer(ST_REGISTERED, '0, 0);
          end
        end
        return table_answer(ST_FULL, '0, 0);
      end
      MODE_DEREG: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i] && tbl_pool[i] == it.pool_id) begin
            tbl_valid[i] = 1'b0;
            return table_answer(ST_REMOVED, '0, 0);
          end
        end
        return table_answer(ST_NOT_FOUND, '0, 0);
      end
      MODE_LOOKUP: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i] && tbl_start[i] <= it.fault_addr &&
              it.fault_addr < tbl_end[i])
            return table_answer(ST_HIT, tbl_pool[i], 1);
        end
        return table_answer(ST_MISS, '0, 0);
      end
      default: return table_answer(ST_MISS, '0, 0);
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t make_op(mode_e m, logic [ID_W-1:0] id, logic [63:0] lo,
                                       logic [63:0] hi, logic [63:0] addr);
    in_item_t it;
    it.mode        = m;
    it.pool_id     = id;
    it.range_start = lo;
    it.range_end   = hi;
    it.fault_addr  = addr;
    return it;
  endfunction

  function automatic in_item_t random_op();
    in_item_t it;
    logic [63:0] base;
    int unsigned sel, width_bits;
    it  = make_op(MODE_REG, ID_W'($urandom), rand64(), rand64(), rand64());
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      it.mode = MODE_REG;
      if ($urandom_range(0, 3) == 0 || used_ids.size() == 0)
        it.pool_id = ID_W'($urandom);
      else
        it.pool_id = used_ids[$urandom_range(0, used_ids.size() - 1)];
      if ($urandom_range(0, 9) != 0) begin
        width_bits = $urandom_range(1, 40);
        base = rand64();
        it.range_start = base;
        it.range_end   = base + (64'($urandom) >> (32 - (width_bits % 32))) + 1;
      end
      used_ids.push_back(it.pool_id);
      used_addrs.push_back(it.range_start);
      if (used_ids.size() > 80) used_ids.delete(0);
      if (used_addrs.size() > 80) used_addrs.delete(0);
    end else if (sel < 65) begin
      it.mode = MODE_DEREG;
      if ($urandom_range(0, 4) != 0 && used_ids.size() != 0)
        it.pool_id = used_ids[$urandom_range(0, used_ids.size() - 1)];
    end else if (sel < 97) begin
      it.mode = MODE_LOOKUP;
      if ($urandom_range(0, 4) != 0 && used_addrs.size() != 0)
        it.fault_addr = used_addrs[$urandom_range(0, used_addrs.size() - 1)]
                        + 64'($urandom_range(0, 3)) - 64'(1);
    end else begin
      it.mode = MODE_NONE;
    end
    return it;
  endfunction

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
    // Boundaries, empty and inverted ranges, duplicate ids, unknown mode.
    pending_items.push_back(make_op(MODE_LOOKUP, 16'h0, '0, '0, '0));
    pending_items.push_back(make_op(MODE_DEREG, 16'hFFFF, '0, '0, '0));
    pending_items.push_back(make_op(MODE_REG, 16'd65535, 64'd100, 64'd200, '0));
    pending_items.push_back(make_op(MODE_REG, 16'd9999, '0, '1, '1));
    pending_items.push_back(make_op(MODE_REG, 16'd1234, 64'd50, 64'd50, '0));
    pending_items.push_back(make_op(MODE_REG, 16'd1234, 64'd60, 64'd40, '0));
    pending_items.push_back(make_op(MODE_REG, 16'd0, '1, '0, '0));
    pending_items.push_back(make_op(MODE_LOOKUP, '0, '0, '0, 64'd100));
    pending_items.push_back(make_op(MODE_LOOKUP, '0, '0, '0, 64'd199));
    pending_items.push_back(make_op(MODE_LOOKUP, '0, '0, '0, 64'd200));
    pending_items.push_back(make_op(MODE_LOOKUP, '0, '0, '0, '1));
    pending_items.push_back(make_op(MODE_LOOKUP, '0, '0, '0, 64'd50));
    pending_items.push_back(make_op(MODE_NONE, 16'hFFFF, '1, '1, 64'd150));
    pending_items.push_back(make_op(MODE_DEREG, 16'd1234, '0, '0, '0));
    pending_items.push_back(make_op(MODE_DEREG, 16'd65535, '0, '0, '0));
    pending_items.push_back(make_op(MODE_LOOKUP, '0, '0, '0, 64'd150));
    pending_items.push_back(make_op(MODE_DEREG, 16'd9999, '0, '0, '0));
    pending_items.push_back(make_op(MODE_LOOKUP, '0, '0, '0, 64'd150));
    // Fill past capacity to reach the full answer, then look up an entry near the end of the table.
    for (int i = 0; i < TABLE_DEPTH + 2; i++)
      pending_items.push_back(make_op(MODE_REG, ID_W'(40000 + i), 64'(1000 + i * 10),
                                      64'(1010 + i * 10), '0));
    pending_items.push_back(make_op(MODE_LOOKUP, '0, '0, '0, 64'(1000 + 60 * 10 + 5)));
    for (int i = 0; i < TABLE_DEPTH; i++)
      pending_items.push_back(make_op(MODE_DEREG, ID_W'(40000 + i), '0, '0, '0));
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) begin
        wait (pending_items.size() == 0);
        hold_sender = 1;
        wait (expected_results.size() == 0);
        hold_sender = 0;
      end
      pending_items.push_back(random_op());
    end
    stimulus_done = 1;
  end

  // Sender side.
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else if (in_valid_i && !in_ready_o) begin
      // Hold the current transaction.
    end else if (send_gap != 0) begin
      in_valid_i <= 1'b0;
      send_gap   <= send_gap - 1;
    end else if (pending_items.size() != 0 && !hold_sender) begin
      in_item_t it;
      it = pending_items.pop_front();
      expected_results.push_back(apply_table_op(it));
      in_valid_i <= 1'b1;
      in_data_i  <= it;
      send_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver side.
  int unsigned recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_item_t want;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %h", out_data_o);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data_o.status);
            error_count++;
          end
          if (out_data_o.hit_pool_id !== want.hit_pool_id) begin
            $error("hit_pool_id expected %0d actual %0d", want.hit_pool_id,
                   out_data_o.hit_pool_id);
            error_count++;
          end
          if (out_data_o.char_thousands !== want.char_thousands) begin
            $error("char_thousands expected %0d actual %0d", want.char_thousands,
                   out_data_o.char_thousands);
            error_count++;
          end
          if (out_data_o.char_hundreds !== want.char_hundreds) begin
            $error("char_hundreds expected %0d actual %0d", want.char_hundreds,
                   out_data_o.char_hundreds);
            error_count++;
          end
          if (out_data_o.char_tens !== want.char_tens) begin
            $error("char_tens expected %0d actual %0d", want.char_tens,
                   out_data_o.char_tens);
            error_count++;
          end
          if (out_data_o.char_ones !== want.char_ones) begin
            $error("char_ones expected %0d actual %0d", want.char_ones,
                   out_data_o.char_ones);
            error_count++;
          end
        end
      end
      if (recv_gap != 0) begin
        out_ready_i <= 1'b0;
        recv_gap    <= recv_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i)
          recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stimulus_done && pending_items.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

endmodule
